[design/rpfl_pkg.sv]
// Package for the record pool free list: pool size, field widths, item and
// result structs, action codes, controller states and command/status structs.
// Depends on nothing; every other file of the block but rpfl_ram imports it.
package rpfl_pkg;

  localparam int POOL_ENTRIES = 100;
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int LINK_W = 8;
  localparam int CMP_W = LINK_W + 1;
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int TYPE_W = 16;
  localparam int ACT_W = 2;
  localparam int SLOT_W = 7;
  localparam int KIND_W = 15;

  localparam logic [LINK_W-1:0] LINK_END = '1;
  localparam logic [TYPE_W-1:0] TYPE_FREE = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC       = 2'd0,
    ACT_RELEASE     = 2'd1,
    ACT_RELEASE_ALL = 2'd2
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot_index;
    logic [KIND_W-1:0] kind;
  } item_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] granted_index;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_step;
  } dp_cmd_t;

  typedef struct packed {
    logic in_sweep;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

  // Link value that an entry holds after reset: the next index, or the end
  // marker for the last entry.
  function automatic logic [LINK_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] link;
    if (int'(idx) == POOL_ENTRIES - 1) begin
      link = LINK_END;
    end else begin
      link = LINK_W'(int'(idx) + 1);
    end
    return link;
  endfunction

endpackage

[design/record_pool_free_list.sv]
// Top level of the record pool free list allocator.
// Depends on rpfl_pkg, rpfl_ctrl and rpfl_dp.
//
// Usage: one input channel (in_valid_i, in_stall_o, in_item_i) carries
// commands: allocate, release one slot, or release all active slots. One
// output channel (out_valid_o, out_stall_i, out_item_o) returns exactly one
// result per command. A transfer happens at a rising edge where valid is
// high and stall is low.
// For allocate and release, the accept cycle reads the target entry from
// the type and link RAMs, and the execute state then evaluates, writes
// back and loads the result register once the output register has room.
// The result is visible in the cycle after the load; a new command is
// taken only once the previous one has executed. Release-all walks the
// pool from the highest entry to the lowest, one entry per cycle with the
// next read overlapped; the last entry waits for room to load the result.
// At reset every entry is free and the list runs in ascending order; valid
// bits stand in for the RAM contents, so there is no clearing pass and the
// block accepts commands as soon as reset is released.
// When the receiver stalls, the result waits in the output register; the
// next command is still accepted, and it finishes once that result leaves.
module record_pool_free_list (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rpfl_pkg::item_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rpfl_pkg::result_t out_item_o
);
  import rpfl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns sequencing; it sees the datapath only through the
  // command and status structs.
  rpfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the pool RAMs, the list head, the free count and the
  // result register that parts the output side from the input side.
  rpfl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

[design/rpfl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module rpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rpfl_ctrl.sv]
// Controller of the record pool free list: sequences accept, execute and the
// release-all sweep. Depends on rpfl_pkg.
module rpfl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rpfl_pkg::dp_status_t status_i,
  output rpfl_pkg::dp_cmd_t    cmd_o
);
  import rpfl_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.in_sweep ? ST_SWEEP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // The final entry also loads the result, so it waits for room.
        if (!status_i.sweep_last) begin
          cmd_o.sweep_step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.sweep_step = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/rpfl_dp.sv]
// Datapath of the record pool free list: type and link RAMs with valid bits,
// head and count registers, sweep index and the result register.
// Depends on rpfl_pkg and rpfl_ram.
module rpfl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rpfl_pkg::item_t      in_item_i,
  input  rpfl_pkg::dp_cmd_t    cmd_i,
  output rpfl_pkg::dp_status_t status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output rpfl_pkg::result_t    out_item_o
);
  import rpfl_pkg::*;

  item_t                    item_q;
  logic [IDX_W-1:0]         rd_addr_q;
  logic [IDX_W-1:0]         sweep_idx_q, sweep_idx_d;
  logic [LINK_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [POOL_ENTRIES-1:0]  type_vld_q, type_vld_d;
  logic [POOL_ENTRIES-1:0]  link_vld_q, link_vld_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_q, out_d;

  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [TYPE_W-1:0]        type_rdata, type_eff, type_wdata;
  logic [LINK_W-1:0]        link_rdata, link_eff;
  logic                     type_we, link_we;
  logic                     head_ok, in_slot_ok, q_slot_ok;
  logic                     alloc_do, rel_do, sweep_fin, load;
  action_e                  q_act;

  assign head_ok    = (count_q != '0) && (CMP_W'(head_q) < CMP_W'(POOL_ENTRIES));
  assign in_slot_ok = CMP_W'(in_item_i.slot_index) < CMP_W'(POOL_ENTRIES);
  assign q_slot_ok  = CMP_W'(item_q.slot_index) < CMP_W'(POOL_ENTRIES);
  assign q_act      = action_e'(item_q.action);

  // Read side: the target entry is read at accept, and during the sweep the
  // next lower entry is read while the current one is processed.
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    sweep_idx_d = sweep_idx_q;
    if (cmd_i.accept) begin
      rd_en       = 1'b1;
      sweep_idx_d = IDX_W'(POOL_ENTRIES - 1);
      unique case (action_e'(in_item_i.action))
        ACT_ALLOC:       rd_addr = head_ok ? IDX_W'(head_q) : '0;
        ACT_RELEASE:     rd_addr = in_slot_ok ? IDX_W'(in_item_i.slot_index) : '0;
        ACT_RELEASE_ALL: rd_addr = IDX_W'(POOL_ENTRIES - 1);
        default:         rd_addr = '0;
      endcase
    end else if (cmd_i.sweep_step && (sweep_idx_q != '0)) begin
      rd_en       = 1'b1;
      rd_addr     = sweep_idx_q - 1'b1;
      sweep_idx_d = sweep_idx_q - 1'b1;
    end
  end

  // Entries never written since reset read as their reset values.
  assign type_eff = type_vld_q[rd_addr_q] ? type_rdata : TYPE_FREE;
  assign link_eff = link_vld_q[rd_addr_q] ? link_rdata : link_reset(rd_addr_q);

  assign alloc_do  = cmd_i.exec && (q_act == ACT_ALLOC) && head_ok;
  assign rel_do    = (cmd_i.exec && (q_act == ACT_RELEASE) && q_slot_ok &&
                      !type_eff[TYPE_W-1]) ||
                     (cmd_i.sweep_step && !type_eff[TYPE_W-1]);
  assign sweep_fin = cmd_i.sweep_step && (sweep_idx_q == '0);
  assign load      = cmd_i.exec || sweep_fin;

  assign type_we    = alloc_do || rel_do;
  assign type_wdata = alloc_do ? TYPE_W'(item_q.kind) : TYPE_FREE;
  assign link_we    = rel_do;

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    type_vld_d = type_vld_q;
    link_vld_d = link_vld_q;
    if (alloc_do) begin
      head_d  = link_eff;
      count_d = count_q - 1'b1;
    end else if (rel_do) begin
      head_d  = LINK_W'(rd_addr_q);
      count_d = count_q + 1'b1;
    end
    if (type_we) begin
      type_vld_d[rd_addr_q] = 1'b1;
    end
    if (link_we) begin
      link_vld_d[rd_addr_q] = 1'b1;
    end
  end

  always_comb begin
    out_d               = out_q;
    out_valid_d         = out_stall_i ? out_valid_q : 1'b0;
    if (load) begin
      out_valid_d         = 1'b1;
      out_d.success       = alloc_do || rel_do || sweep_fin;
      out_d.granted_index = alloc_do ? head_q[SLOT_W-1:0] : '0;
    end
  end

  rpfl_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (POOL_ENTRIES)
  ) u_type_ram (
    .clk_i   (clk_i),
    .we_i    (type_we),
    .waddr_i (rd_addr_q),
    .wdata_i (type_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (type_rdata)
  );

  rpfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (rd_addr_q),
    .wdata_i (head_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= CNT_W'(POOL_ENTRIES);
      type_vld_q  <= '0;
      link_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      type_vld_q  <= type_vld_d;
      link_vld_q  <= link_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_item_i;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    sweep_idx_q <= sweep_idx_d;
    out_q       <= out_d;
  end

  assign status_o.in_sweep   = action_e'(in_item_i.action) == ACT_RELEASE_ALL;
  assign status_o.sweep_last = sweep_idx_q == '0;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POOL_ENTRIES))
    else $error("free count exceeds pool size");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    type_we |-> (!rd_en || (rd_addr != rd_addr_q)))
    else $error("read and write hit the same entry in one cycle");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q) |-> !out_stall_i)
    else $error("result register loaded while a stalled result is held");
`endif

endmodule
